[rtl/core/lead_obstacle_selector_core_assert.svh]
// assertion macros used by the checker file los_checker.sv
`ifndef LEAD_OBSTACLE_SELECTOR_CORE_ASSERT_SVH
`define LEAD_OBSTACLE_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define LOS_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed: %m");

// next-cycle implication
`define LOS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed: %m");

`endif

[rtl/core/los_pkg.sv]
`default_nettype none

package los_pkg;

  localparam int unsigned MAX_OBSTACLES_DEF = 256;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD  = 2'd0,
    CFG_HALF_WIDTH = 2'd1,
    CFG_COS_THRESH = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_DATA_W-1:0] LOOKAHEAD_RST  = 16'd1920;
  localparam logic [CFG_DATA_W-1:0] HALF_WIDTH_RST = 16'd384;
  localparam logic [CFG_DATA_W-1:0] COS_THRESH_RST = 16'd29491;

  // registers hold the squared limits
  localparam logic [2*CFG_DATA_W-1:0] LSQ_RST = 32'(LOOKAHEAD_RST) * 32'(LOOKAHEAD_RST);
  localparam logic [2*CFG_DATA_W-1:0] WSQ_RST = 32'(HALF_WIDTH_RST) * 32'(HALF_WIDTH_RST);
  localparam logic [2*CFG_DATA_W-1:0] CSQ_RST = 32'(COS_THRESH_RST) * 32'(COS_THRESH_RST);

  typedef struct packed {
    logic signed [23:0] car_x;
    logic signed [23:0] car_y;
    logic signed [23:0] car_vx;
    logic signed [23:0] car_vy;
    logic signed [23:0] obstacle_x;
    logic signed [23:0] obstacle_y;
    logic               last_in_scan;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] lead_index;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  // multiplier operand sources
  typedef enum logic [4:0] {
    OPND_DX,
    OPND_DY,
    OPND_VX,
    OPND_VY,
    OPND_DOT_LO,
    OPND_DOT_HI,
    OPND_CRS_LO,
    OPND_CRS_HI,
    OPND_D2_LO,
    OPND_D2_HI,
    OPND_V2_LO,
    OPND_V2_HI,
    OPND_DV_0,
    OPND_DV_1,
    OPND_DV_2,
    OPND_C2,
    OPND_L2,
    OPND_W2
  } opnd_e;

  typedef enum logic [2:0] {
    SH_0,
    SH_32,
    SH_33,
    SH_64,
    SH_96
  } shift_e;

  // where a finished sum goes
  typedef enum logic [3:0] {
    DST_NONE,
    DST_DOT,
    DST_CRS,
    DST_D2,
    DST_V2,
    DST_DOT2,
    DST_CRS2,
    DST_D2V2,
    DST_LV,
    DST_WV,
    DST_RHS
  } dest_e;

  typedef struct packed {
    opnd_e  a_sel;
    opnd_e  b_sel;
    shift_e sh;
    logic   first;
    logic   sub;
    dest_e  dest;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic issue;
    uop_t uop;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  localparam int unsigned NUM_STEPS = 25;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

  function automatic uop_t mk_uop(opnd_e a, opnd_e b, shift_e sh, logic first, logic sub,
                                  dest_e dest);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sh    = sh;
    u.first = first;
    u.sub   = sub;
    u.dest  = dest;
    return u;
  endfunction

  // multiply-accumulate program for one obstacle
  function automatic uop_t ucode(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      5'd0:    u = mk_uop(OPND_DX,     OPND_VX,     SH_0,  1'b1, 1'b0, DST_NONE);
      5'd1:    u = mk_uop(OPND_DY,     OPND_VY,     SH_0,  1'b0, 1'b0, DST_DOT);
      5'd2:    u = mk_uop(OPND_VX,     OPND_DY,     SH_0,  1'b1, 1'b0, DST_NONE);
      5'd3:    u = mk_uop(OPND_VY,     OPND_DX,     SH_0,  1'b0, 1'b1, DST_CRS);
      5'd4:    u = mk_uop(OPND_DX,     OPND_DX,     SH_0,  1'b1, 1'b0, DST_NONE);
      5'd5:    u = mk_uop(OPND_DY,     OPND_DY,     SH_0,  1'b0, 1'b0, DST_D2);
      5'd6:    u = mk_uop(OPND_VX,     OPND_VX,     SH_0,  1'b1, 1'b0, DST_NONE);
      5'd7:    u = mk_uop(OPND_VY,     OPND_VY,     SH_0,  1'b0, 1'b0, DST_V2);
      5'd8:    u = mk_uop(OPND_DOT_LO, OPND_DOT_LO, SH_0,  1'b1, 1'b0, DST_NONE);
      5'd9:    u = mk_uop(OPND_DOT_LO, OPND_DOT_HI, SH_33, 1'b0, 1'b0, DST_NONE);
      5'd10:   u = mk_uop(OPND_DOT_HI, OPND_DOT_HI, SH_64, 1'b0, 1'b0, DST_DOT2);
      5'd11:   u = mk_uop(OPND_CRS_LO, OPND_CRS_LO, SH_0,  1'b1, 1'b0, DST_NONE);
      5'd12:   u = mk_uop(OPND_CRS_LO, OPND_CRS_HI, SH_33, 1'b0, 1'b0, DST_NONE);
      5'd13:   u = mk_uop(OPND_CRS_HI, OPND_CRS_HI, SH_64, 1'b0, 1'b0, DST_CRS2);
      5'd14:   u = mk_uop(OPND_D2_LO,  OPND_V2_LO,  SH_0,  1'b1, 1'b0, DST_NONE);
      5'd15:   u = mk_uop(OPND_D2_LO,  OPND_V2_HI,  SH_32, 1'b0, 1'b0, DST_NONE);
      5'd16:   u = mk_uop(OPND_D2_HI,  OPND_V2_LO,  SH_32, 1'b0, 1'b0, DST_NONE);
      5'd17:   u = mk_uop(OPND_D2_HI,  OPND_V2_HI,  SH_64, 1'b0, 1'b0, DST_D2V2);
      5'd18:   u = mk_uop(OPND_L2,     OPND_V2_LO,  SH_0,  1'b1, 1'b0, DST_NONE);
      5'd19:   u = mk_uop(OPND_L2,     OPND_V2_HI,  SH_32, 1'b0, 1'b0, DST_LV);
      5'd20:   u = mk_uop(OPND_W2,     OPND_V2_LO,  SH_0,  1'b1, 1'b0, DST_NONE);
      5'd21:   u = mk_uop(OPND_W2,     OPND_V2_HI,  SH_32, 1'b0, 1'b0, DST_WV);
      5'd22:   u = mk_uop(OPND_DV_0,   OPND_C2,     SH_0,  1'b1, 1'b0, DST_NONE);
      5'd23:   u = mk_uop(OPND_DV_1,   OPND_C2,     SH_32, 1'b0, 1'b0, DST_NONE);
      5'd24:   u = mk_uop(OPND_DV_2,   OPND_C2,     SH_64, 1'b0, 1'b0, DST_RHS);
      default: u = mk_uop(OPND_DX,     OPND_DX,     SH_0,  1'b1, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lead_obstacle_selector_core.sv]
// lead obstacle selector
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one obstacle per item,
// together with the own car position and velocity. last_in_scan closes a scan.
// Output channel (out_valid_o / out_stall_i / out_item_o): one item per scan,
// found and the scan position of the last obstacle in the lane box ahead.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 lookahead distance, 1 half lane width, 2 cosine threshold); write only
// while the block is idle.
// The block takes no new item until the current one is through. A single
// 33x33 signed multiplier with a 130-bit accumulator runs a 25-step program
// per obstacle, after an accept state and before an accumulate drain and a
// commit state. out_valid_o is registered and rises after the last commit.
// The finished result sits in an output register; the next item is accepted
// while it waits. If the result of the following scan is ready while the
// receiver still stalls, the block holds that item until the register frees.
// Reset clears the scan state, the output valid and restores the register
// defaults.
`default_nettype none

module lead_obstacle_selector_core #(
  parameter int unsigned MAX_OBSTACLES = los_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  los_pkg::in_t                    in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output los_pkg::out_t                   out_item_o,
  input  logic                            cfg_we_i,
  input  logic [los_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [los_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import los_pkg::*;

  cmd_t cmd;
  sts_t sts;

  los_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  los_datapath #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[rtl/core/los_ctrl.sv]
`default_nettype none

module los_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  los_pkg::sts_t  sts_i,
  output los_pkg::cmd_t  cmd_o
);
  import los_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_W'(NUM_STEPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // the end of a scan waits for the output register to free up
        if (!sts_i.last || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue   = (state_q == ST_RUN);
    cmd_o.uop     = ucode(step_q);
    cmd_o.commit  = (state_q == ST_DONE) && (!sts_i.last || out_free);
    out_valid_d   = (out_valid_q && out_stall_i) || (cmd_o.commit && sts_i.last);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/los_datapath.sv]
`default_nettype none

module los_datapath #(
  parameter int unsigned MAX_OBSTACLES = los_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  los_pkg::cmd_t                   cmd_i,
  output los_pkg::sts_t                   sts_o,
  input  los_pkg::in_t                    in_item_i,
  input  logic                            cfg_we_i,
  input  logic [los_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [los_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output los_pkg::out_t                   out_item_o
);
  import los_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_OBSTACLES + 1);

  // squared limits
  logic [2*CFG_DATA_W-1:0] cfg_sq;
  logic [2*CFG_DATA_W-1:0] lsq_q, wsq_q, csq_q;

  // captured item
  logic signed [24:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [23:0] vx_q, vy_q;
  logic               last_q;

  // intermediate results
  logic signed [48:0] dot_q;
  logic [47:0]        crs_q;
  logic [48:0]        d2_q;
  logic [47:0]        v2_q;
  logic [95:0]        dot2_q, crs2_q, dv_q;
  logic               cos_ok_q, lv_ok_q, wv_ok_q;

  // multiply-accumulate
  logic signed [32:0]  opa, opb;
  logic signed [65:0]  prod_d, prod_q;
  uop_t                uop_q;
  logic                issue_q;
  logic signed [129:0] prod_ext, addend, base, acc_d, acc_q, acc_neg;
  logic [47:0]         crs_mag;

  // scan state
  logic [POS_W-1:0] scan_pos_q, scan_pos_d, upd_scan;
  logic [POS_W-1:0] best_pos_q, best_pos_d, upd_pos;
  logic             best_valid_q, best_valid_d, upd_valid;
  logic [POS_W+7:0] pos_ext;
  logic             dot_pos, qual, in_range;
  out_t             out_d, out_item_q;

  assign cfg_sq = cfg_wdata_i * cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsq_q <= LSQ_RST;
      wsq_q <= WSQ_RST;
      csq_q <= CSQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOOKAHEAD:  lsq_q <= cfg_sq;
        CFG_HALF_WIDTH: wsq_q <= cfg_sq;
        CFG_COS_THRESH: csq_q <= cfg_sq;
        default: ;
      endcase
    end
  end

  assign dx_d = {in_item_i.obstacle_x[23], in_item_i.obstacle_x}
              - {in_item_i.car_x[23], in_item_i.car_x};
  assign dy_d = {in_item_i.obstacle_y[23], in_item_i.obstacle_y}
              - {in_item_i.car_y[23], in_item_i.car_y};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      vx_q   <= in_item_i.car_vx;
      vy_q   <= in_item_i.car_vy;
      last_q <= in_item_i.last_in_scan;
    end
  end

  assign sts_o.last = last_q;

  function automatic logic signed [32:0] opnd_val(opnd_e sel);
    logic signed [32:0] v;
    case (sel)
      OPND_DX:     v = {{8{dx_q[24]}}, dx_q};
      OPND_DY:     v = {{8{dy_q[24]}}, dy_q};
      OPND_VX:     v = {{9{vx_q[23]}}, vx_q};
      OPND_VY:     v = {{9{vy_q[23]}}, vy_q};
      OPND_DOT_LO: v = {1'b0, dot_q[31:0]};
      OPND_DOT_HI: v = {17'b0, dot_q[47:32]};
      OPND_CRS_LO: v = {1'b0, crs_q[31:0]};
      OPND_CRS_HI: v = {17'b0, crs_q[47:32]};
      OPND_D2_LO:  v = {1'b0, d2_q[31:0]};
      OPND_D2_HI:  v = {16'b0, d2_q[48:32]};
      OPND_V2_LO:  v = {1'b0, v2_q[31:0]};
      OPND_V2_HI:  v = {17'b0, v2_q[47:32]};
      OPND_DV_0:   v = {1'b0, dv_q[31:0]};
      OPND_DV_1:   v = {1'b0, dv_q[63:32]};
      OPND_DV_2:   v = {1'b0, dv_q[95:64]};
      OPND_C2:     v = {1'b0, csq_q};
      OPND_L2:     v = {1'b0, lsq_q};
      OPND_W2:     v = {1'b0, wsq_q};
      default:     v = '0;
    endcase
    return v;
  endfunction

  assign opa    = opnd_val(cmd_i.uop.a_sel);
  assign opb    = opnd_val(cmd_i.uop.b_sel);
  assign prod_d = opa * opb;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    uop_q  <= cmd_i.uop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= cmd_i.issue;
    end
  end

  assign prod_ext = {{64{prod_q[65]}}, prod_q};

  always_comb begin
    case (uop_q.sh)
      SH_0:    addend = prod_ext;
      SH_32:   addend = prod_ext <<< 32;
      SH_33:   addend = prod_ext <<< 33;
      SH_64:   addend = prod_ext <<< 64;
      SH_96:   addend = prod_ext <<< 96;
      default: addend = prod_ext;
    endcase
    base    = uop_q.first ? '0 : acc_q;
    acc_d   = uop_q.sub ? (base - addend) : (base + addend);
    acc_neg = -acc_d;
    crs_mag = acc_d[129] ? acc_neg[47:0] : acc_d[47:0];
  end

  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      acc_q <= acc_d;
      case (uop_q.dest)
        DST_DOT:  dot_q  <= acc_d[48:0];
        DST_CRS:  crs_q  <= crs_mag;
        DST_D2:   d2_q   <= acc_d[48:0];
        DST_V2:   v2_q   <= acc_d[47:0];
        DST_DOT2: dot2_q <= acc_d[95:0];
        DST_CRS2: crs2_q <= acc_d[95:0];
        DST_D2V2: dv_q   <= acc_d[95:0];
        DST_LV:   lv_ok_q  <= ({32'b0, dot2_q} < acc_d[127:0]);
        DST_WV:   wv_ok_q  <= ({32'b0, crs2_q} < acc_d[127:0]);
        DST_RHS:  cos_ok_q <= ({dot2_q, 32'b0} >= acc_d[127:0]);
        default: ;
      endcase
    end
  end

  // scan bookkeeping
  always_comb begin
    dot_pos   = !dot_q[48] && (dot_q != '0);
    qual      = dot_pos && cos_ok_q && lv_ok_q && wv_ok_q;
    in_range  = (scan_pos_q < POS_W'(MAX_OBSTACLES));
    upd_valid = best_valid_q;
    upd_pos   = best_pos_q;
    upd_scan  = scan_pos_q;
    if (in_range) begin
      if (qual) begin
        upd_valid = 1'b1;
        upd_pos   = scan_pos_q;
      end
      upd_scan = scan_pos_q + 1'b1;
    end
    pos_ext          = {8'b0, upd_pos};
    out_d.found      = upd_valid;
    out_d.lead_index = upd_valid ? pos_ext[7:0] : 8'd0;

    scan_pos_d   = scan_pos_q;
    best_pos_d   = best_pos_q;
    best_valid_d = best_valid_q;
    if (cmd_i.commit) begin
      if (last_q) begin
        scan_pos_d   = '0;
        best_pos_d   = '0;
        best_valid_d = 1'b0;
      end else begin
        scan_pos_d   = upd_scan;
        best_pos_d   = upd_pos;
        best_valid_d = upd_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pos_q   <= '0;
      best_pos_q   <= '0;
      best_valid_q <= 1'b0;
    end else begin
      scan_pos_q   <= scan_pos_d;
      best_pos_q   <= best_pos_d;
      best_valid_q <= best_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && last_q) begin
      out_item_q <= out_d;
    end
  end

  assign out_item_o = out_item_q;

endmodule

`default_nettype wire

[rtl/core/los_checker.sv]
`default_nettype none
`include "lead_obstacle_selector_core_assert.svh"

module los_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input los_pkg::out_t                   out_item_o
);
  import los_pkg::*;

  // a stalled result stays put
  `LOS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // empty scans report index zero
  `LOS_ASSERT_NOW(a_none_index_zero, clk_i, rst_ni, out_valid_o && !out_item_o.found, out_item_o.lead_index == 8'd0)

  // one item at a time through the multiplier
  `LOS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // no result can appear right after an item is taken
  `LOS_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o)

endmodule

bind lead_obstacle_selector_core los_checker u_los_checker (.*);

`default_nettype wire
